>>> hdl/sqlts_pkg.sv
`timescale 1ns / 1ps
// sqlts_pkg: shared types, character codes and a helper function for the
// sql terminator scanner; no dependencies
package sqlts_pkg;

   // scan state, including the pending one-byte lookahead cases
   typedef enum logic [2:0] {
      MODE_CODE       = 3'd0,
      MODE_CODE_DASH  = 3'd1,
      MODE_CODE_SLASH = 3'd2,
      MODE_STR        = 3'd3,
      MODE_STR_QUOTE  = 3'd4,
      MODE_LINE       = 3'd5,
      MODE_BLOCK      = 3'd6,
      MODE_BLOCK_STAR = 3'd7
   } scan_mode_type;

   typedef enum logic [1:0] {
      REGION_CODE   = 2'd0,
      REGION_STRING = 2'd1,
      REGION_LINE   = 2'd2,
      REGION_BLOCK  = 2'd3
   } region_type;

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   // outcome of scanning one byte
   typedef struct packed {
      logic          term;
      scan_mode_type next_mode;
   } step_type;

   function automatic region_type region_of_mode(input scan_mode_type mode);
      region_type r;
      unique case (mode)
         MODE_CODE, MODE_CODE_DASH, MODE_CODE_SLASH: r = REGION_CODE;
         MODE_STR, MODE_STR_QUOTE:                   r = REGION_STRING;
         MODE_LINE:                                  r = REGION_LINE;
         MODE_BLOCK, MODE_BLOCK_STAR:                r = REGION_BLOCK;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/sqlts_channels.sv
`timescale 1ns / 1ps
// sqlts_req_if, sqlts_rsp_if: valid/ready channels carrying text bytes in
// and scan results out; payload widths are fixed, no package use
interface sqlts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sqlts_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_terminator;
   logic       terminator_seen;
   logic [1:0] region_after;
   logic       text_done;

   modport source (output valid, output is_terminator, output terminator_seen,
                   output region_after, output text_done, input ready);
   modport sink   (input valid, input is_terminator, input terminator_seen,
                   input region_after, input text_done, output ready);
endinterface

>>> hdl/sqlts_step.sv
`timescale 1ns / 1ps
// sqlts_step: one-byte transition of the comment and string aware scanner
// depends on sqlts_pkg
module sqlts_step (
   input  sqlts_pkg::scan_mode_type mode,
   input  logic [7:0]               text_byte,
   output sqlts_pkg::step_type      step
);

   logic          is_quote, is_dash, is_slash, is_star, is_semi, is_nl;
   sqlts_pkg::step_type code_step;

   assign is_quote = (text_byte == sqlts_pkg::CHAR_QUOTE);
   assign is_dash  = (text_byte == sqlts_pkg::CHAR_DASH);
   assign is_slash = (text_byte == sqlts_pkg::CHAR_SLASH);
   assign is_star  = (text_byte == sqlts_pkg::CHAR_STAR);
   assign is_semi  = (text_byte == sqlts_pkg::CHAR_SEMI);
   assign is_nl    = (text_byte == sqlts_pkg::CHAR_NL);

   // byte scanned as plain code
   always_comb begin
      code_step.term = 1'b0;
      if (is_quote)
         code_step.next_mode = sqlts_pkg::MODE_STR;
      else if (is_dash)
         code_step.next_mode = sqlts_pkg::MODE_CODE_DASH;
      else if (is_slash)
         code_step.next_mode = sqlts_pkg::MODE_CODE_SLASH;
      else begin
         code_step.next_mode = sqlts_pkg::MODE_CODE;
         code_step.term      = is_semi;
      end
   end

   always_comb begin
      step.term      = 1'b0;
      step.next_mode = mode;
      unique case (mode)
         sqlts_pkg::MODE_CODE: begin
            step = code_step;
         end
         sqlts_pkg::MODE_CODE_DASH: begin
            if (is_dash) step.next_mode = sqlts_pkg::MODE_LINE;
            else step = code_step;
         end
         sqlts_pkg::MODE_CODE_SLASH: begin
            if (is_star) step.next_mode = sqlts_pkg::MODE_BLOCK;
            else step = code_step;
         end
         sqlts_pkg::MODE_STR: begin
            step.next_mode = is_quote ? sqlts_pkg::MODE_STR_QUOTE : sqlts_pkg::MODE_STR;
         end
         sqlts_pkg::MODE_STR_QUOTE: begin
            // doubled quote is an escape, anything else closes the string
            if (is_quote) step.next_mode = sqlts_pkg::MODE_STR;
            else step = code_step;
         end
         sqlts_pkg::MODE_LINE: begin
            step.next_mode = is_nl ? sqlts_pkg::MODE_CODE : sqlts_pkg::MODE_LINE;
         end
         sqlts_pkg::MODE_BLOCK: begin
            step.next_mode = is_star ? sqlts_pkg::MODE_BLOCK_STAR : sqlts_pkg::MODE_BLOCK;
         end
         sqlts_pkg::MODE_BLOCK_STAR: begin
            if (is_slash)     step.next_mode = sqlts_pkg::MODE_CODE;
            else if (is_star) step.next_mode = sqlts_pkg::MODE_BLOCK_STAR;
            else              step.next_mode = sqlts_pkg::MODE_BLOCK;
         end
      endcase
   end

endmodule

>>> hdl/sql_terminator_scanner_core.sv
`timescale 1ns / 1ps
// sql_terminator_scanner_core: top level of the sql terminator scanner
// depends on sqlts_pkg, sqlts_req_if / sqlts_rsp_if and sqlts_step
//
// Scans SQL text one byte per beat and flags semicolons that sit in code,
// outside single-quoted strings, "--" line comments and slash-star block
// comments. Every request beat yields exactly one response beat, in order:
// is_terminator for this byte, terminator_seen (sticky over the text so far),
// the region after the byte and text_done, a copy of end_of_text. On the
// text_done beat terminator_seen is the answer for the whole text; after it
// the scanner is back in code with the sticky flag clear. Throughput is one
// byte per clock with back-to-back beats while rsp_ch.ready stays high; a
// byte passes an input register and a result register, and the 3-bit scan
// state and the sticky flag update between them. The result register lets a
// new byte enter while a finished result still waits on rsp_ch.ready. There
// is no configuration and no memory; reset is synchronous and active high.
module sql_terminator_scanner_core (
   input  logic        clock,
   input  logic        reset,
   sqlts_req_if.sink   req_ch,
   sqlts_rsp_if.source rsp_ch
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic       out_term_ff, out_seen_ff, out_done_ff;
   logic [1:0] out_region_ff;

   // scan state
   sqlts_pkg::scan_mode_type mode_ff, mode_in;
   logic                     seen_ff, seen_in;

   sqlts_pkg::step_type step;
   logic                advance;
   logic                seen_now;

   // the held byte moves into the result register when that is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   sqlts_step u_step (
      .mode      (mode_ff),
      .text_byte (in_byte_ff),
      .step      (step)
   );

   assign seen_now = seen_ff | step.term;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.ready) in_valid_in = req_ch.valid;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_ch.ready) out_valid_in = 1'b0;

      mode_in = mode_ff;
      seen_in = seen_ff;
      if (advance) begin
         // end of text drops any pending byte or open region
         mode_in = in_eot_ff ? sqlts_pkg::MODE_CODE : step.next_mode;
         seen_in = in_eot_ff ? 1'b0 : seen_now;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= sqlts_pkg::MODE_CODE;
         seen_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         seen_ff      <= seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.text_byte;
         in_eot_ff  <= req_ch.end_of_text;
      end
      if (advance) begin
         out_term_ff   <= step.term;
         out_seen_ff   <= seen_now;
         out_region_ff <= 2'(sqlts_pkg::region_of_mode(step.next_mode));
         out_done_ff   <= in_eot_ff;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.is_terminator   = out_term_ff;
   assign rsp_ch.terminator_seen = out_seen_ff;
   assign rsp_ch.region_after    = out_region_ff;
   assign rsp_ch.text_done       = out_done_ff;

endmodule

>>> hdl/sqlts_checker.sv
`timescale 1ns / 1ps
// sqlts_checker: port-level assertions for sql_terminator_scanner_core,
// bound to the top level; depends on sqlts_pkg
module sqlts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_terminator,
   input logic       rsp_terminator_seen,
   input logic [1:0] rsp_region_after,
   input logic       rsp_text_done
);

   logic rsp_beat;
   assign rsp_beat = rsp_valid && rsp_ready;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_terminator)
         && $stable(rsp_terminator_seen) && $stable(rsp_region_after)
         && $stable(rsp_text_done))
      else $error("stalled response changed");

   // the sticky flag stays set within a text
   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_terminator_seen && !rsp_text_done
         |=> (rsp_beat |-> rsp_terminator_seen))
      else $error("terminator_seen dropped inside a text");

   // a new text starts with a clear sticky flag
   a_seen_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_text_done |=> (rsp_beat |-> rsp_terminator_seen == rsp_is_terminator))
      else $error("terminator_seen carried across texts");

   // a line comment ends only in code, and hides semicolons
   a_line_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_text_done && rsp_region_after == sqlts_pkg::REGION_LINE
         |=> (rsp_beat |-> !rsp_is_terminator
              && (rsp_region_after == sqlts_pkg::REGION_LINE
                  || rsp_region_after == sqlts_pkg::REGION_CODE)))
      else $error("bad exit from line comment");

endmodule

bind sql_terminator_scanner_core sqlts_checker u_sqlts_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_is_terminator   (rsp_ch.is_terminator),
   .rsp_terminator_seen (rsp_ch.terminator_seen),
   .rsp_region_after    (rsp_ch.region_after),
   .rsp_text_done       (rsp_ch.text_done)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sql_terminator_scanner_core, driving sql text beats
// and checking every result beat; depends on sqlts_pkg and sqlts_req_if / sqlts_rsp_if
module tb_top;

   localparam int TEXT_BYTES_WANTED = 1800;
   localparam int QUIET_LIMIT       = 2000;  // cycles with no beat on either side
   localparam int SETTLE_CYCLES     = 10;    // margin after the last result beat

   // one byte of text waiting to be sent
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         drain_first;  // hold this beat until all results are back
   } text_beat_type;

   // what the scanner must report for one byte
   typedef struct {
      logic                  is_term;
      logic                  seen;
      sqlts_pkg::region_type region;
      logic                  done;
   } scan_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sqlts_req_if req_ch ();
   sqlts_rsp_if rsp_ch ();

   sql_terminator_scanner_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #4 clock = ~clock;

   text_beat_type    bytes_pending[$];
   scan_verdict_type verdicts_due[$];

   // scanner state as the bench predicts it
   sqlts_pkg::scan_mode_type mode_now = sqlts_pkg::MODE_CODE;
   logic                     seen_now = 1'b0;

   int bytes_queued   = 0;
   int bytes_accepted = 0;
   int mismatch_count = 0;
   int texts_done     = 0;
   int terms_found    = 0;
   int region_hits[4] = '{0, 0, 0, 0};

   int send_wait = 0;
   bit send_calm = 1'b0;
   int recv_wait = 0;
   bit recv_calm = 1'b0;
   int quiet_cycles = 0;

   string code_chars = "abcdefghijklmnopqrstuvwxyz0123456789_=<>(),.* ";
   string tricky_chars = ";'-/*\n";

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // plain code byte: may open a string, start a pending dash or slash,
   // or be a terminator
   function automatic void code_mode(input logic [7:0] ch,
                                     output sqlts_pkg::scan_mode_type m,
                                     inout logic term);
      if (ch == sqlts_pkg::CHAR_QUOTE) m = sqlts_pkg::MODE_STR;
      else if (ch == sqlts_pkg::CHAR_DASH) m = sqlts_pkg::MODE_CODE_DASH;
      else if (ch == sqlts_pkg::CHAR_SLASH) m = sqlts_pkg::MODE_CODE_SLASH;
      else begin
         m = sqlts_pkg::MODE_CODE;
         if (ch == sqlts_pkg::CHAR_SEMI) term = 1'b1;
      end
   endfunction

   // advances the predicted state by one byte and returns the expected result
   function automatic scan_verdict_type predict_scan(input logic [7:0] ch, input logic last);
      scan_verdict_type v;
      sqlts_pkg::scan_mode_type nxt;
      logic term;
      term = 1'b0;
      case (mode_now)
         sqlts_pkg::MODE_CODE_DASH: begin
            if (ch == sqlts_pkg::CHAR_DASH) nxt = sqlts_pkg::MODE_LINE;
            else code_mode(ch, nxt, term);
         end
         sqlts_pkg::MODE_CODE_SLASH: begin
            if (ch == sqlts_pkg::CHAR_STAR) nxt = sqlts_pkg::MODE_BLOCK;
            else code_mode(ch, nxt, term);
         end
         sqlts_pkg::MODE_STR:
            nxt = (ch == sqlts_pkg::CHAR_QUOTE) ? sqlts_pkg::MODE_STR_QUOTE
                                                : sqlts_pkg::MODE_STR;
         // a second quote is an escape, anything else closes the string
         sqlts_pkg::MODE_STR_QUOTE: begin
            if (ch == sqlts_pkg::CHAR_QUOTE) nxt = sqlts_pkg::MODE_STR;
            else code_mode(ch, nxt, term);
         end
         sqlts_pkg::MODE_LINE:
            nxt = (ch == sqlts_pkg::CHAR_NL) ? sqlts_pkg::MODE_CODE : sqlts_pkg::MODE_LINE;
         sqlts_pkg::MODE_BLOCK:
            nxt = (ch == sqlts_pkg::CHAR_STAR) ? sqlts_pkg::MODE_BLOCK_STAR
                                               : sqlts_pkg::MODE_BLOCK;
         sqlts_pkg::MODE_BLOCK_STAR: begin
            if (ch == sqlts_pkg::CHAR_SLASH) nxt = sqlts_pkg::MODE_CODE;
            else if (ch == sqlts_pkg::CHAR_STAR) nxt = sqlts_pkg::MODE_BLOCK_STAR;
            else nxt = sqlts_pkg::MODE_BLOCK;
         end
         default: code_mode(ch, nxt, term);
      endcase
      if (term) seen_now = 1'b1;
      v.is_term = term;
      v.seen    = seen_now;
      v.done    = last;
      // pending dash/slash count as code, pending quote as string
      case (nxt)
         sqlts_pkg::MODE_STR, sqlts_pkg::MODE_STR_QUOTE:
            v.region = sqlts_pkg::REGION_STRING;
         sqlts_pkg::MODE_LINE:
            v.region = sqlts_pkg::REGION_LINE;
         sqlts_pkg::MODE_BLOCK, sqlts_pkg::MODE_BLOCK_STAR:
            v.region = sqlts_pkg::REGION_BLOCK;
         default:
            v.region = sqlts_pkg::REGION_CODE;
      endcase
      // end of text drops whatever is open and clears the sticky flag
      if (last) begin
         mode_now = sqlts_pkg::MODE_CODE;
         seen_now = 1'b0;
      end else begin
         mode_now = nxt;
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] ch, input logic last,
                                      input bit drain_first);
      text_beat_type b;
      b.ch          = ch;
      b.last        = last;
      b.drain_first = drain_first;
      bytes_pending.insert(bytes_pending.size(), b);
      bytes_queued++;
   endfunction

   // directed text given as a string; last byte optionally ends the text
   function automatic void queue_string(input string s, input logic ends_text,
                                        input bit drain_first);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], ends_text && (i == s.len() - 1), drain_first && (i == 0));
   endfunction

   function automatic logic [7:0] plain_char();
      return code_chars[$urandom_range(0, code_chars.len() - 1)];
   endfunction

   // content for strings and comments: half of the picks are bytes that matter to the scanner
   function automatic logic [7:0] inner_char();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return tricky_chars[$urandom_range(0, tricky_chars.len() - 1)];
      else if (pick < 8) return plain_char();
      else return 8'($urandom);
   endfunction

   // one random text: mostly well-formed sql pieces, sometimes raw noise,
   // sometimes cut short so the text can end inside a string, comment or pending byte
   function automatic void queue_random_text(input bit drain_first);
      logic [7:0] txt[$];
      logic [7:0] ch;
      int cut;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) txt.insert(txt.size(), 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
               0, 1: repeat ($urandom_range(1, 6)) txt.insert(txt.size(), plain_char());
               2: txt.insert(txt.size(), sqlts_pkg::CHAR_SEMI);
               3: begin
                  txt.insert(txt.size(), sqlts_pkg::CHAR_QUOTE);
                  repeat ($urandom_range(0, 6)) begin
                     ch = inner_char();
                     txt.insert(txt.size(), ch);
                     // escaped quote
                     if (ch == sqlts_pkg::CHAR_QUOTE)
                        txt.insert(txt.size(), sqlts_pkg::CHAR_QUOTE);
                  end
                  txt.insert(txt.size(), sqlts_pkg::CHAR_QUOTE);
               end
               4: begin
                  txt.insert(txt.size(), sqlts_pkg::CHAR_DASH);
                  txt.insert(txt.size(), sqlts_pkg::CHAR_DASH);
                  repeat ($urandom_range(0, 6)) begin
                     ch = inner_char();
                     txt.insert(txt.size(), (ch == sqlts_pkg::CHAR_NL) ? 8'h78 : ch);
                  end
                  txt.insert(txt.size(), sqlts_pkg::CHAR_NL);
               end
               5: begin
                  txt.insert(txt.size(), sqlts_pkg::CHAR_SLASH);
                  txt.insert(txt.size(), sqlts_pkg::CHAR_STAR);
                  repeat ($urandom_range(0, 6)) begin
                     ch = inner_char();
                     // keep the comment open until its proper close
                     if (ch == sqlts_pkg::CHAR_SLASH
                         && txt[txt.size() - 1] == sqlts_pkg::CHAR_STAR)
                        ch = 8'h20;
                     txt.insert(txt.size(), ch);
                  end
                  repeat ($urandom_range(1, 3)) txt.insert(txt.size(), sqlts_pkg::CHAR_STAR);
                  txt.insert(txt.size(), sqlts_pkg::CHAR_SLASH);
               end
               6: begin
                  // lone dash or slash that turns out to be plain code
                  txt.insert(txt.size(), $urandom_range(0, 1) ? sqlts_pkg::CHAR_DASH
                                                              : sqlts_pkg::CHAR_SLASH);
                  case ($urandom_range(0, 2))
                     0: txt.insert(txt.size(), sqlts_pkg::CHAR_SEMI);
                     1: txt.insert(txt.size(), sqlts_pkg::CHAR_QUOTE);
                     default: txt.insert(txt.size(), plain_char());
                  endcase
               end
               7: txt.insert(txt.size(), 8'($urandom));
               default: txt.insert(txt.size(), $urandom_range(0, 1) ? sqlts_pkg::CHAR_NL
                                                                    : 8'h20);
            endcase
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, txt.size());
         while (txt.size() > cut) txt.delete(txt.size() - 1);
      end
      foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1, drain_first && (i == 0));
   endfunction

   // ------------------------------------------------------------------
   // driver: one beat at a time from bytes_pending, random gaps between beats
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.text_byte   <= 8'h00;
         req_ch.end_of_text <= 1'b0;
      end else begin
         // beat taken at this edge: predict its result right away
         if (req_ch.valid && req_ch.ready) begin
            verdicts_due.insert(verdicts_due.size(),
                                predict_scan(req_ch.text_byte, req_ch.end_of_text));
            bytes_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_ch.valid <= 1'b0;
            end else if (bytes_pending.size() != 0 &&
                         !(bytes_pending[0].drain_first && verdicts_due.size() != 0)) begin
               req_ch.valid       <= 1'b1;
               req_ch.text_byte   <= bytes_pending[0].ch;
               req_ch.end_of_text <= bytes_pending[0].last;
               bytes_pending.delete(0);
               // switch now and then between gappy and back-to-back stretches
               if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
               send_wait = send_calm ? 0 : $urandom_range(0, 19);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: checks each result beat against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdicts_due.size() == 0) begin
               $error("result beat with no byte outstanding");
               mismatch_count++;
            end else begin
               if (rsp_ch.is_terminator !== verdicts_due[0].is_term) begin
                  $error("is_terminator: expected %0d, actual %0d",
                         verdicts_due[0].is_term, rsp_ch.is_terminator);
                  mismatch_count++;
               end
               if (rsp_ch.terminator_seen !== verdicts_due[0].seen) begin
                  $error("terminator_seen: expected %0d, actual %0d",
                         verdicts_due[0].seen, rsp_ch.terminator_seen);
                  mismatch_count++;
               end
               if (rsp_ch.region_after !== verdicts_due[0].region) begin
                  $error("region_after: expected %0d, actual %0d",
                         verdicts_due[0].region, rsp_ch.region_after);
                  mismatch_count++;
               end
               if (rsp_ch.text_done !== verdicts_due[0].done) begin
                  $error("text_done: expected %0d, actual %0d",
                         verdicts_due[0].done, rsp_ch.text_done);
                  mismatch_count++;
               end
               if (verdicts_due[0].done) texts_done++;
               if (verdicts_due[0].is_term) terms_found++;
               region_hits[verdicts_due[0].region]++;
               verdicts_due.delete(0);
            end
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: no beat on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, verdicts_due.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.text_byte   = 8'h00;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;

      // directed: byte extremes, repeated terminators, pending dash and slash
      // falling back to code, line comment, block comment with a run of stars,
      // an opening star that cannot close, escaped and closing quotes
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_string(";;", 1'b1, 1'b0);
      queue_string("-x/;", 1'b0, 1'b0);
      queue_string("--;\n", 1'b0, 1'b0);
      queue_string("/***/", 1'b0, 1'b0);
      queue_string("/*/", 1'b1, 1'b1);      // text ends inside the block comment
      queue_string("''';';", 1'b1, 1'b0);   // ';' in string, then ';' after close

      // random texts; the first one waits for an empty pipe
      queue_random_text(1'b1);
      while (bytes_queued < TEXT_BYTES_WANTED) queue_random_text($urandom_range(0, 29) == 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_queued) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("scanned %0d bytes in %0d texts, %0d terminators flagged",
               bytes_accepted, texts_done, terms_found);
      $display("bytes ending in code/string/line/block: %0d/%0d/%0d/%0d, %0d mismatches",
               region_hits[0], region_hits[1], region_hits[2], region_hits[3],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
